// ----- sv/plc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

    localparam logic [1:0] K_PUSH   = 2'd0;
    localparam logic [1:0] K_INSERT = 2'd1;
    localparam logic [1:0] K_DELETE = 2'd2;
    localparam logic [1:0] K_READ   = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BELOW  = 3'd1;
    localparam logic [2:0] ST_BEYOND = 3'd2;
    localparam logic [2:0] ST_NONE   = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         length;
    } t_out_item;

    typedef struct packed {
        logic                  ins;
        logic                  del;
        logic                  rd;
        logic [IDX_W-1:0]      at;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_ctrl;

    function automatic logic [31:0] widen(input logic [DATA_WIDTH-1:0] d);
        logic signed [63:0] t;
        t = 64'(signed'(d));
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/plc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plc_cell (
    input  wire logic                          i_clk,
    input  wire logic [plc_pkg::IDX_W-1:0]     i_index,
    input  wire plc_pkg::t_cell_ctrl           i_ctrl,
    input  wire logic [plc_pkg::DATA_WIDTH-1:0] i_left,
    input  wire logic [plc_pkg::DATA_WIDTH-1:0] i_right,
    output logic [plc_pkg::DATA_WIDTH-1:0]      o_data,
    output logic [plc_pkg::DATA_WIDTH-1:0]      o_tap
);

    logic [plc_pkg::DATA_WIDTH-1:0] r_data;
    logic [plc_pkg::DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (i_index > i_ctrl.at) begin
                n_data = i_left;
            end else if (i_index == i_ctrl.at) begin
                n_data = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            if (i_index >= i_ctrl.at) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (i_ctrl.rd && (i_index == i_ctrl.at)) ? r_data : '0;

endmodule

`default_nettype wire

// ----- sv/positional_list_engine_core.sv -----
// Ordered list of up to plc_pkg::CAPACITY values held in a row of cells, position 1 in cell 0.
// Every item (push front, insert, delete or read at a position) acts on the whole row at once:
// each cell compares its own index with the position and shifts from its neighbour, or loads,
// at the same edge, and a read picks the matching cell. Results leave through one output
// register, so an item can be taken every cycle while the downstream side keeps up. The list
// comes out of reset empty and ready for use.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire plc_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output plc_pkg::t_out_item      o_out_item
);

    logic                         r_out_valid;
    plc_pkg::t_out_item           r_out_item;
    logic [plc_pkg::CNT_W-1:0]    r_count;
    logic [plc_pkg::CNT_W-1:0]    n_count;

    logic                         accept;
    logic [plc_pkg::CMP_W-1:0]    pos_w;
    logic [plc_pkg::CMP_W-1:0]    cnt1;
    logic [plc_pkg::CMP_W-1:0]    pos_m1;
    logic [2:0]                   status;
    logic                         full;
    plc_pkg::t_cell_ctrl          ctrl;
    logic [plc_pkg::DATA_WIDTH-1:0] rd_data;
    logic [31:0]                  len_ext;

    logic [plc_pkg::DATA_WIDTH-1:0] cell_data [plc_pkg::CAPACITY];
    logic [plc_pkg::DATA_WIDTH-1:0] cell_tap  [plc_pkg::CAPACITY];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign pos_w  = plc_pkg::CMP_W'(i_in_item.position);
    assign cnt1   = plc_pkg::CMP_W'(r_count) + plc_pkg::CMP_W'(1);
    assign pos_m1 = pos_w - plc_pkg::CMP_W'(1);
    assign full   = (r_count == plc_pkg::CNT_W'(plc_pkg::CAPACITY));

    always_comb begin
        status     = plc_pkg::ST_OK;
        ctrl.ins   = 1'b0;
        ctrl.del   = 1'b0;
        ctrl.rd    = 1'b0;
        ctrl.at    = pos_m1[plc_pkg::IDX_W-1:0];
        ctrl.value = plc_pkg::DATA_WIDTH'($unsigned(i_in_item.value));
        n_count    = r_count;
        case (i_in_item.kind)
            plc_pkg::K_PUSH: begin
                ctrl.at = '0;
                if (full) begin
                    status = plc_pkg::ST_FULL;
                end
            end
            plc_pkg::K_INSERT: begin
                if (pos_w == '0) begin
                    status = plc_pkg::ST_BELOW;
                end else if (pos_w > cnt1) begin
                    status = plc_pkg::ST_BEYOND;
                end else if (full) begin
                    status = plc_pkg::ST_FULL;
                end
            end
            default: begin
                if (pos_w == '0) begin
                    status = plc_pkg::ST_BELOW;
                end else if (pos_w > cnt1) begin
                    status = plc_pkg::ST_BEYOND;
                end else if (pos_w == cnt1) begin
                    status = plc_pkg::ST_NONE;
                end
            end
        endcase
        if (accept && status == plc_pkg::ST_OK) begin
            case (i_in_item.kind)
                plc_pkg::K_PUSH, plc_pkg::K_INSERT: begin
                    ctrl.ins = 1'b1;
                    n_count  = r_count + plc_pkg::CNT_W'(1);
                end
                plc_pkg::K_DELETE: begin
                    ctrl.del = 1'b1;
                    n_count  = r_count - plc_pkg::CNT_W'(1);
                end
                default: begin
                    ctrl.rd = 1'b1;
                end
            endcase
        end
    end

    for (genvar g = 0; g < plc_pkg::CAPACITY; g++) begin : g_cell
        plc_cell u_cell (
            .i_clk   (i_clk),
            .i_index (plc_pkg::IDX_W'(g)),
            .i_ctrl  (ctrl),
            .i_left  ((g == 0) ? ctrl.value : cell_data[(g == 0) ? 0 : g - 1]),
            .i_right ((g == plc_pkg::CAPACITY - 1) ? cell_data[g]
                      : cell_data[(g == plc_pkg::CAPACITY - 1) ? g : g + 1]),
            .o_data  (cell_data[g]),
            .o_tap   (cell_tap[g])
        );
    end

    // one-hot taps, so an or over the row selects the read cell
    always_comb begin
        rd_data = '0;
        for (int k = 0; k < plc_pkg::CAPACITY; k++) begin
            rd_data = rd_data | cell_tap[k];
        end
    end

    assign len_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item.status     <= status;
            r_out_item.read_value <= ctrl.rd ? plc_pkg::widen(rd_data) : '0;
            r_out_item.length     <= len_ext[6:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;
    localparam int BLOCKS      = 12;
    localparam int BLOCK_ITEMS = 100;

    typedef enum logic [1:0] {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } t_mix_mode;

    class list_scoreboard;
        logic signed [31:0]  cells [plc_pkg::CAPACITY];
        int unsigned         count;
        plc_pkg::t_out_item  pending_q[$];
        int unsigned         errors;

        function void note_request(input plc_pkg::t_in_item req);
            plc_pkg::t_out_item exp_res;
            int        at;
            int        i;
            int        pos;
            exp_res = '0;
            pos = req.position;
            at = 0;
            if (req.kind == plc_pkg::K_PUSH || req.kind == plc_pkg::K_INSERT) begin
                exp_res.status = plc_pkg::ST_OK;
                if (req.kind == plc_pkg::K_INSERT) begin
                    if (pos < 1)
                        exp_res.status = plc_pkg::ST_BELOW;
                    else if (pos > count + 1)
                        exp_res.status = plc_pkg::ST_BEYOND;
                    else
                        at = pos - 1;
                end
                if (exp_res.status == plc_pkg::ST_OK && count >= plc_pkg::CAPACITY)
                    exp_res.status = plc_pkg::ST_FULL;
                if (exp_res.status == plc_pkg::ST_OK) begin
                    for (i = count; i > at; i--)
                        cells[i] = cells[i-1];
                    cells[at] = req.value;
                    count++;
                end
            end else begin
                if (pos < 1)
                    exp_res.status = plc_pkg::ST_BELOW;
                else if (pos > count + 1)
                    exp_res.status = plc_pkg::ST_BEYOND;
                else if (pos == count + 1)
                    exp_res.status = plc_pkg::ST_NONE;
                else
                    exp_res.status = plc_pkg::ST_OK;
                if (exp_res.status == plc_pkg::ST_OK) begin
                    at = pos - 1;
                    if (req.kind == plc_pkg::K_DELETE) begin
                        for (i = at; i + 1 < count; i++)
                            cells[i] = cells[i+1];
                        count--;
                    end else begin
                        exp_res.read_value = cells[at];
                    end
                end
            end
            exp_res.length = 7'(count);
            pending_q.push_back(exp_res);
        endfunction

        function void check_result(input plc_pkg::t_out_item got);
            plc_pkg::t_out_item exp_res;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d read_value=%0d length=%0d",
                         $time, got.status, got.read_value, got.length);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (got.status !== exp_res.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_res.status, got.status);
                errors++;
            end
            if (got.read_value !== exp_res.read_value) begin
                $display("%0t: read_value expected %0d actual %0d",
                         $time, exp_res.read_value, got.read_value);
                errors++;
            end
            if (got.length !== exp_res.length) begin
                $display("%0t: length expected %0d actual %0d",
                         $time, exp_res.length, got.length);
                errors++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    plc_pkg::t_in_item  in_item   = '0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    plc_pkg::t_out_item out_item;

    list_scoreboard sb = new();
    bit             idle_on      = 1'b1;
    bit             hold_request = 1'b0;
    int             stall_cycles = 0;

    positional_list_engine_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_request(in_item);
            if (out_valid && out_ready)
                sb.check_result(out_item);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic plc_pkg::t_in_item make_req(input logic [1:0] kind,
                                                   input logic [31:0] value,
                                                   input int pos);
        plc_pkg::t_in_item req;
        req.kind     = kind;
        req.value    = value;
        req.position = 8'(pos);
        return req;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_position(input int unsigned cur_count);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, cur_count + 1);
        else if (r < 78)
            return 0;
        else if (r < 88)
            return $urandom_range(cur_count + 2, 255);
        else
            return $urandom_range(0, 255);
    endfunction

    function automatic logic [1:0] pick_kind(input t_mix_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                if (r < 45)      return plc_pkg::K_PUSH;
                else if (r < 85) return plc_pkg::K_INSERT;
                else if (r < 95) return plc_pkg::K_READ;
                else             return plc_pkg::K_DELETE;
            end
            MODE_SHRINK: begin
                if (r < 60)      return plc_pkg::K_DELETE;
                else if (r < 80) return plc_pkg::K_READ;
                else if (r < 90) return plc_pkg::K_PUSH;
                else             return plc_pkg::K_INSERT;
            end
            default: begin
                return 2'($urandom_range(0, 3));
            end
        endcase
    endfunction

    task automatic send_request(input plc_pkg::t_in_item req);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
    endtask

    // the last accepted item is noted at the edge just passed
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    // result side: per-item back-pressure, one long hold on request
    initial begin
        int gap;
        repeat (11) @(posedge clk);
        forever begin
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = idle_on ? $urandom_range(0, 14) : 0;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        t_mix_mode mode;
        int        blk;
        int        n;
        logic [1:0] kind;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty and small list corner cases
        send_request(make_req(plc_pkg::K_READ,   32'h0, 0));
        send_request(make_req(plc_pkg::K_READ,   32'h0, 1));
        send_request(make_req(plc_pkg::K_DELETE, 32'h0, 2));
        send_request(make_req(plc_pkg::K_DELETE, 32'h0, 255));
        send_request(make_req(plc_pkg::K_INSERT, 32'h1234_5678, 0));
        send_request(make_req(plc_pkg::K_INSERT, 32'h1234_5678, 2));
        send_request(make_req(plc_pkg::K_INSERT, 32'h7fff_ffff, 1));
        send_request(make_req(plc_pkg::K_PUSH,   32'h8000_0000, 0));
        send_request(make_req(plc_pkg::K_PUSH,   32'hffff_ffff, 255));
        send_request(make_req(plc_pkg::K_INSERT, 32'h0000_0000, 4));
        send_request(make_req(plc_pkg::K_INSERT, 32'h5a5a_5a5a, 2));
        send_request(make_req(plc_pkg::K_READ,   32'hdead_beef, 1));
        send_request(make_req(plc_pkg::K_READ,   32'h0, 5));
        send_request(make_req(plc_pkg::K_READ,   32'h0, 6));
        send_request(make_req(plc_pkg::K_READ,   32'h0, 7));
        send_request(make_req(plc_pkg::K_DELETE, 32'h0, 3));
        send_request(make_req(plc_pkg::K_DELETE, 32'h0, 4));
        send_request(make_req(plc_pkg::K_DELETE, 32'h0, 1));
        send_request(make_req(plc_pkg::K_READ,   32'h0, 255));
        send_request(make_req(plc_pkg::K_DELETE, 32'h0, 0));
        send_request(make_req(plc_pkg::K_INSERT, 32'h00ff_00ff, 255));

        for (blk = 0; blk < BLOCKS; blk++) begin
            case (blk % 4)
                0, 1:    mode = MODE_GROW;
                2:       mode = MODE_SHRINK;
                default: mode = MODE_MIXED;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            if (blk == 2)
                hold_request = 1'b1;
            for (n = 0; n < BLOCK_ITEMS; n++) begin
                kind = pick_kind(mode);
                send_request(make_req(kind, pick_value(), pick_position(sb.count)));
            end
            if (blk == 5) begin
                in_valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/plc_pkg.sv
sv/plc_cell.sv
sv/positional_list_engine_core.sv
bench/testbench.sv
